FILE: hdl/pidx_pkg.sv
// ============================================================================
// Pot/encoder index calibration: shared package
// Holds the control word layout, the microcode program and the divider control.
// ============================================================================
package pidx_pkg;

    // Widths fixed by the interface.
    localparam int POS_W      = 32;
    localparam int UNITS_W    = 24;
    localparam int MINS_W     = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 32;

    // Divider datapath widths.
    localparam int REM_W      = 32;
    localparam int DQ_W       = 36;
    localparam int STEPS_W    = 6;

    // Iteration counts, loaded as count minus one.
    localparam logic [STEPS_W-1:0] AVG_LAST_STEP = 6'd31;
    localparam logic [STEPS_W-1:0] SEC_LAST_STEP = 6'd35;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_UNITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES   = 1'b1;

    // Program counter of the sequencer.
    localparam int STEP_W = 3;

    typedef enum logic [2:0] {
        OP_TAKE,
        OP_UPDATE,
        OP_AVG_LOAD,
        OP_DIV_STEP,
        OP_SEC_LOAD,
        OP_APPLY,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NO_INPUT,
        COND_SKIP_CAL,
        COND_LOOP,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // The program. A taken condition jumps to target, otherwise the step
    // counter advances; the emit step falls through to step zero by wrap.
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
        uword_t w;
        begin
            case (addr)
                3'd0:    w = '{op: OP_TAKE,     cond: COND_NO_INPUT, target: 3'd0};
                3'd1:    w = '{op: OP_UPDATE,   cond: COND_NEXT,     target: 3'd0};
                3'd2:    w = '{op: OP_AVG_LOAD, cond: COND_SKIP_CAL, target: 3'd7};
                3'd3:    w = '{op: OP_DIV_STEP, cond: COND_LOOP,     target: 3'd3};
                3'd4:    w = '{op: OP_SEC_LOAD, cond: COND_NEXT,     target: 3'd0};
                3'd5:    w = '{op: OP_DIV_STEP, cond: COND_LOOP,     target: 3'd5};
                3'd6:    w = '{op: OP_APPLY,    cond: COND_NEXT,     target: 3'd0};
                3'd7:    w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: 3'd7};
                default: w = '{op: OP_TAKE,     cond: COND_NO_INPUT, target: 3'd0};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: hdl/pidx_div.sv
// ============================================================================
// Pot/encoder index calibration: shared divider
// Restoring unsigned divider, one quotient bit per step, with its own
// step counter.
// ============================================================================
module pidx_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pidx_pkg::div_ctrl_t               ctrl,
    input  logic [pidx_pkg::REM_W-1:0]        load_rem,
    input  logic [pidx_pkg::DQ_W-1:0]         load_dq,
    input  logic [pidx_pkg::REM_W-1:0]        load_divisor,
    input  logic [pidx_pkg::STEPS_W-1:0]      load_steps,
    output logic [pidx_pkg::REM_W-1:0]        rem,
    output logic [pidx_pkg::DQ_W-1:0]         dq,
    output logic                              more
);

    logic [pidx_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [pidx_pkg::DQ_W-1:0]    dq_reg, dq_next;
    logic [pidx_pkg::REM_W-1:0]   divisor_reg, divisor_next;
    logic [pidx_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic [pidx_pkg::REM_W:0]     trial;
    logic [pidx_pkg::REM_W:0]     diff;
    logic                         fits;

    always_comb
    begin
        trial        = {rem_reg, dq_reg[pidx_pkg::DQ_W-1]};
        diff         = trial - {1'b0, divisor_reg};
        fits         = (trial >= {1'b0, divisor_reg});
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        steps_next   = steps_reg;
        if (ctrl.load)
        begin
            rem_next     = load_rem;
            dq_next      = load_dq;
            divisor_next = load_divisor;
            steps_next   = load_steps;
        end
        else if (ctrl.step)
        begin
            // The partial remainder stays below the divisor, so it fits.
            rem_next = fits ? diff[pidx_pkg::REM_W-1:0] : trial[pidx_pkg::REM_W-1:0];
            dq_next  = {dq_reg[pidx_pkg::DQ_W-2:0], fits};
            if (steps_reg != '0)
            begin
                steps_next = steps_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
        end
        else
        begin
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign rem  = rem_reg;
    assign dq   = dq_reg;
    assign more = (steps_reg != '0);

endmodule

FILE: hdl/pot_encoder_index_calibration_core.sv
// ============================================================================
// Pot/encoder index calibration core
// Averages pot minus encoder, latches the encoder at index pulses and
// derives an absolute offset for the relative encoder.
// ============================================================================
//
//  Channel  | Direction | Handshake          | Word contents
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | in_valid/in_stall  | encoder_pos, pot_pos, index_seen,
//           |           |                    | restart
//  output   | out       | out_valid/out_stall| calibrated_pos, is_locked,
//           |           |                    | mismatch
//  config   | in        | cfg_wr_en          | cfg_index, cfg_data
//
// A word that skips calibration runs the take, update, average-load and emit
// steps; one that calibrates adds two passes through the shared one-bit-per-
// cycle divider (32 steps for the average, 36 for the section) and an apply.
// The core takes no new word until the last result is in the output register.
// Reset clears all calibration state and loads the register defaults.
// A result word waiting in the output register holds the next at its emit step.
//
// The sequencer runs an eight-step program from a read-only table. Each
// control word selects one datapath operation and a jump condition; the
// divider loops are closed by the divider's own step counter.
//
module pot_encoder_index_calibration_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [pidx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidx_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pidx_pkg::POS_W-1:0]   encoder_pos,
    input  logic signed [pidx_pkg::POS_W-1:0]   pot_pos,
    input  logic                                index_seen,
    input  logic                                restart,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pidx_pkg::POS_W-1:0]   calibrated_pos,
    output logic                                is_locked,
    output logic                                mismatch
);

    // ------------------------------------------------------------------
    // Saturates a 38-bit two's complement value to 32 bits.
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat32(input logic [37:0] v);
        logic [31:0] r;
        begin
            if ((v[37:31] == 7'h00) || (v[37:31] == 7'h7F))
            begin
                r = v[31:0];
            end
            else if (v[37])
            begin
                r = 32'h8000_0000;
            end
            else
            begin
                r = 32'h7FFF_FFFF;
            end
            return r;
        end
    endfunction

    // Sequencer.
    logic [pidx_pkg::STEP_W-1:0] step_reg, step_next;
    pidx_pkg::uword_t            uw;
    logic                        jump;
    logic                        in_acc;
    logic                        out_busy;
    logic                        calib_ok;

    // Configuration registers.
    logic [pidx_pkg::UNITS_W-1:0] units_reg, units_next;
    logic [pidx_pkg::MINS_W-1:0]  min_samples_reg, min_samples_next;
    logic [pidx_pkg::UNITS_W-1:0] units_eff;

    // Latched input word.
    logic [31:0] enc_reg, pot_reg;
    logic        idx_reg, rst_reg;

    // Calibration state.
    logic [31:0] offset_reg, offset_next;
    logic [63:0] diff_sum_reg, diff_sum_next;
    logic [31:0] count_reg, count_next;
    logic        pending_reg, pending_next;
    logic [31:0] pulse_pos_reg, pulse_pos_next;
    logic        locked_reg, locked_next;
    logic        error_reg, error_next;
    logic [35:0] num_reg, num_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pos_reg, out_pos_next;
    logic        out_locked_reg, out_locked_next;
    logic        out_error_reg, out_error_next;

    // Datapath intermediates.
    logic [32:0] diff;
    logic [64:0] sum_ext;
    logic [63:0] sum_sat;
    logic [63:0] sum_mag;
    logic [33:0] quo_ext;
    logic [33:0] avg;
    logic [34:0] filt;
    logic [35:0] num;
    logic [35:0] num_mag;
    logic [36:0] num_ext;
    logic [36:0] rem_ext;
    logic [36:0] adj;
    logic [36:0] half;
    logic [36:0] secu;
    logic [37:0] cand_wide;
    logic [31:0] cand;
    logic [37:0] emit_wide;

    // Divider interface.
    pidx_pkg::div_ctrl_t               div_ctrl;
    logic [pidx_pkg::REM_W-1:0]        div_load_rem;
    logic [pidx_pkg::DQ_W-1:0]         div_load_dq;
    logic [pidx_pkg::REM_W-1:0]        div_load_divisor;
    logic [pidx_pkg::STEPS_W-1:0]      div_load_steps;
    logic [pidx_pkg::REM_W-1:0]        div_rem;
    logic [pidx_pkg::DQ_W-1:0]         div_dq;
    logic                              div_more;

    assign uw       = pidx_pkg::ucode_rom(step_reg);
    assign in_stall = (uw.op != pidx_pkg::OP_TAKE);
    assign in_acc   = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;
    assign calib_ok = pending_reg && (count_reg >= {16'd0, min_samples_reg});
    assign units_eff = (units_reg == '0) ? 24'd1 : units_reg;

    // ------------------------------------------------------------------
    // Step counter and jump logic.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (uw.cond)
            pidx_pkg::COND_NEXT:     jump = 1'b0;
            pidx_pkg::COND_NO_INPUT: jump = !in_acc;
            pidx_pkg::COND_SKIP_CAL: jump = !calib_ok;
            pidx_pkg::COND_LOOP:     jump = div_more;
            pidx_pkg::COND_OUT_BUSY: jump = out_busy;
            default:                 jump = 1'b0;
        endcase
        step_next = jump ? uw.target : step_reg + 1'b1;
    end

    // ------------------------------------------------------------------
    // Datapath arithmetic.
    // ------------------------------------------------------------------
    always_comb
    begin
        // Accumulate pot minus encoder with signed 64-bit saturation.
        diff    = {pot_reg[31], pot_reg} - {enc_reg[31], enc_reg};
        sum_ext = {diff_sum_reg[63], diff_sum_reg} + {{32{diff[32]}}, diff};
        if (sum_ext[64] != sum_ext[63])
        begin
            sum_sat = sum_ext[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            sum_sat = sum_ext[63:0];
        end

        // The average is below 2^32 in magnitude, so the upper half of the
        // magnitude is already a valid partial remainder for the divider.
        sum_mag = diff_sum_reg[63] ? (64'd0 - diff_sum_reg) : diff_sum_reg;

        // Average with its sign, then the doubled section numerator.
        quo_ext = {2'b00, div_dq[31:0]};
        avg     = diff_sum_reg[63] ? (34'd0 - quo_ext) : quo_ext;
        filt    = {{3{pulse_pos_reg[31]}}, pulse_pos_reg} + {avg[33], avg};
        num     = {filt, 1'b0} - {12'd0, units_eff};
        num_mag = num[35] ? (36'd0 - num) : num;

        // With |num| = q*2u + r, section*u is (num - r)/2, plus u when the
        // ceiling rounds up a positive quotient; for a negative numerator
        // it is (num + r)/2. The divided values are always even.
        num_ext = {num_reg[35], num_reg};
        rem_ext = {5'd0, div_rem};
        adj     = num_reg[35] ? (num_ext + rem_ext) : (num_ext - rem_ext);
        half    = {adj[36], adj[36:1]};
        if (!num_reg[35] && (div_rem != '0))
        begin
            secu = half + {13'd0, units_eff};
        end
        else
        begin
            secu = half;
        end
        cand_wide = {secu[36], secu} - {{6{pulse_pos_reg[31]}}, pulse_pos_reg};
        cand      = sat32(cand_wide);

        emit_wide = {{6{enc_reg[31]}}, enc_reg} + {{6{offset_reg[31]}}, offset_reg};
    end

    // ------------------------------------------------------------------
    // Divider control and load values.
    // ------------------------------------------------------------------
    always_comb
    begin
        div_ctrl.load    = 1'b0;
        div_ctrl.step    = (uw.op == pidx_pkg::OP_DIV_STEP);
        div_load_rem     = sum_mag[63:32];
        div_load_dq      = {sum_mag[31:0], 4'd0};
        div_load_divisor = count_reg;
        div_load_steps   = pidx_pkg::AVG_LAST_STEP;
        case (uw.op)
            pidx_pkg::OP_AVG_LOAD:
            begin
                div_ctrl.load = 1'b1;
            end
            pidx_pkg::OP_SEC_LOAD:
            begin
                div_ctrl.load    = 1'b1;
                div_load_rem     = '0;
                div_load_dq      = num_mag;
                div_load_divisor = {7'd0, units_eff, 1'b0};
                div_load_steps   = pidx_pkg::SEC_LAST_STEP;
            end
            default:
            begin
                div_ctrl.load = 1'b0;
            end
        endcase
    end

    pidx_div u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (div_ctrl),
        .load_rem     (div_load_rem),
        .load_dq      (div_load_dq),
        .load_divisor (div_load_divisor),
        .load_steps   (div_load_steps),
        .rem          (div_rem),
        .dq           (div_dq),
        .more         (div_more)
    );

    // ------------------------------------------------------------------
    // State updates per operation.
    // ------------------------------------------------------------------
    always_comb
    begin
        offset_next     = offset_reg;
        diff_sum_next   = diff_sum_reg;
        count_next      = count_reg;
        pending_next    = pending_reg;
        pulse_pos_next  = pulse_pos_reg;
        locked_next     = locked_reg;
        error_next      = error_reg;
        num_next        = num_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_pos_next    = out_pos_reg;
        out_locked_next = out_locked_reg;
        out_error_next  = out_error_reg;
        units_next       = units_reg;
        min_samples_next = min_samples_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                pidx_pkg::REG_SECTION_UNITS: units_next = cfg_data[pidx_pkg::UNITS_W-1:0];
                pidx_pkg::REG_MIN_SAMPLES:   min_samples_next = cfg_data[pidx_pkg::MINS_W-1:0];
                default:                     units_next = units_reg;
            endcase
        end

        case (uw.op)
            pidx_pkg::OP_UPDATE:
            begin
                if (rst_reg)
                begin
                    offset_next    = '0;
                    diff_sum_next  = '0;
                    count_next     = '0;
                    pending_next   = 1'b0;
                    pulse_pos_next = '0;
                    locked_next    = 1'b0;
                    error_next     = 1'b0;
                end
                else
                begin
                    // A full counter freezes both the count and the sum.
                    if (count_reg != '1)
                    begin
                        diff_sum_next = sum_sat;
                        count_next    = count_reg + 1'b1;
                    end
                    if (idx_reg)
                    begin
                        pending_next   = 1'b1;
                        pulse_pos_next = enc_reg;
                    end
                end
            end
            pidx_pkg::OP_SEC_LOAD:
            begin
                num_next = num;
            end
            pidx_pkg::OP_APPLY:
            begin
                if (!locked_reg)
                begin
                    offset_next = cand;
                    locked_next = 1'b1;
                end
                else if (offset_reg != cand)
                begin
                    error_next = 1'b1;
                end
                pending_next = 1'b0;
            end
            pidx_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = sat32(emit_wide);
                    out_locked_next = locked_reg;
                    out_error_next  = error_reg;
                end
            end
            default:
            begin
                num_next = num_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= '0;
            units_reg       <= 24'd256;
            min_samples_reg <= 16'd50;
            offset_reg      <= '0;
            diff_sum_reg    <= '0;
            count_reg       <= '0;
            pending_reg     <= 1'b0;
            pulse_pos_reg   <= '0;
            locked_reg      <= 1'b0;
            error_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg        <= step_next;
            units_reg       <= units_next;
            min_samples_reg <= min_samples_next;
            offset_reg      <= offset_next;
            diff_sum_reg    <= diff_sum_next;
            count_reg       <= count_next;
            pending_reg     <= pending_next;
            pulse_pos_reg   <= pulse_pos_next;
            locked_reg      <= locked_next;
            error_reg       <= error_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            enc_reg <= encoder_pos;
            pot_reg <= pot_pos;
            idx_reg <= index_seen;
            rst_reg <= restart;
        end
        num_reg        <= num_next;
        out_pos_reg    <= out_pos_next;
        out_locked_reg <= out_locked_next;
        out_error_reg  <= out_error_next;
    end

    assign out_valid      = out_valid_reg;
    assign calibrated_pos = out_pos_reg;
    assign is_locked      = out_locked_reg;
    assign mismatch       = out_error_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A mismatch can only be raised once an offset is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> locked_reg)
        else $error("mismatch flag set while not locked");

    // The average division starts from a partial remainder below the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == pidx_pkg::OP_AVG_LOAD && calib_ok) |-> (sum_mag[63:32] < count_reg))
        else $error("average quotient would not fit the divider");

    // Applying a candidate always consumes the pending pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == pidx_pkg::OP_APPLY) |=> !pending_reg)
        else $error("pulse still pending after apply");

endmodule

FILE: tb/index_calibration_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Index calibration checker
// Watches the register port and both word channels of the calibration core,
// predicts every result word from its own copy of the calibration state and
// compares the words that leave the block, field by field, in order.
// ============================================================================
module index_calibration_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  logic [pidx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidx_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [pidx_pkg::POS_W-1:0]    encoder_pos,
    input  logic signed [pidx_pkg::POS_W-1:0]    pot_pos,
    input  logic                                 index_seen,
    input  logic                                 restart,

    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [pidx_pkg::POS_W-1:0]    calibrated_pos,
    input  logic                                 is_locked,
    input  logic                                 mismatch,

    output int                                   fail_count,
    output int                                   outstanding
);

    typedef struct packed {
        logic signed [pidx_pkg::POS_W-1:0] pos;
        logic                              locked;
        logic                              conflict;
    } cal_result_t;

    localparam logic [pidx_pkg::UNITS_W-1:0] UNITS_RESET = 24'd256;
    localparam logic [pidx_pkg::MINS_W-1:0]  MIN_RESET   = 16'd50;
    localparam logic [pidx_pkg::CNT_W-1:0]   COUNT_FULL  = '1;
    localparam longint                       SUM_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint                       SUM_BOTTOM  = 64'sh8000_0000_0000_0000;
    localparam longint                       POS_TOP     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint                       POS_BOTTOM  = 64'shFFFF_FFFF_8000_0000;

    logic [pidx_pkg::UNITS_W-1:0]      section_units;
    logic [pidx_pkg::MINS_W-1:0]       min_samples;
    logic signed [pidx_pkg::POS_W-1:0] offset;
    longint                            diff_sum;
    logic [pidx_pkg::CNT_W-1:0]        sample_count;
    logic                              pulse_pending;
    logic signed [pidx_pkg::POS_W-1:0] pulse_pos;
    logic                              locked;
    logic                              offset_conflict;

    cal_result_t expected_results[$];
    int          errors;

    function automatic logic signed [pidx_pkg::POS_W-1:0] clamp_pos(input longint v);
        if (v > POS_TOP)
            return POS_TOP[pidx_pkg::POS_W-1:0];
        if (v < POS_BOTTOM)
            return POS_BOTTOM[pidx_pkg::POS_W-1:0];
        return v[pidx_pkg::POS_W-1:0];
    endfunction

    function automatic longint add_clamped(input longint a, input longint b);
        if (b > 0 && a > SUM_TOP - b)
            return SUM_TOP;
        if (b < 0 && a < SUM_BOTTOM - b)
            return SUM_BOTTOM;
        return a + b;
    endfunction

    function automatic void clear_calibration();
        offset          = '0;
        diff_sum        = 0;
        sample_count    = '0;
        pulse_pending   = 1'b0;
        pulse_pos       = '0;
        locked          = 1'b0;
        offset_conflict = 1'b0;
    endfunction

    // Advances the calibration state by one input word and returns the word
    // the block should send back for it.
    function automatic cal_result_t predict_calibration(
        input logic signed [pidx_pkg::POS_W-1:0] enc,
        input logic signed [pidx_pkg::POS_W-1:0] pot,
        input logic                              idx,
        input logic                              rst
    );
        cal_result_t                       res;
        longint                            u, avg, filtered, num, den, section;
        logic signed [pidx_pkg::POS_W-1:0] candidate;
        if (rst) begin
            clear_calibration();
        end else begin
            if (sample_count != COUNT_FULL) begin
                diff_sum     = add_clamped(diff_sum, longint'(pot) - longint'(enc));
                sample_count = sample_count + 1'b1;
            end
            if (idx) begin
                pulse_pending = 1'b1;
                pulse_pos     = enc;
            end
            if (pulse_pending && sample_count >= min_samples && sample_count != 0) begin
                u        = (section_units == 0) ? 1 : longint'({40'd0, section_units});
                avg      = diff_sum / longint'({32'd0, sample_count});
                filtered = longint'(pulse_pos) + avg;
                // Half a section is subtracted exactly by doubling both sides.
                num      = 2 * filtered - u;
                den      = 2 * u;
                section  = num / den;
                if (num % den != 0 && num > 0)
                    section = section + 1;
                candidate = clamp_pos(section * u - longint'(pulse_pos));
                if (!locked) begin
                    offset = candidate;
                    locked = 1'b1;
                end else if (offset != candidate) begin
                    offset_conflict = 1'b1;
                end
                pulse_pending = 1'b0;
            end
        end
        res.pos      = clamp_pos(longint'(enc) + longint'(offset));
        res.locked   = locked;
        res.conflict = offset_conflict;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: calibration word mismatch: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cal_result_t want;
        if (!rst_n)
        begin
            section_units   = UNITS_RESET;
            min_samples     = MIN_RESET;
            clear_calibration();
            expected_results.delete();
            errors          = 0;
            fail_count      <= 0;
            outstanding     <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == pidx_pkg::REG_SECTION_UNITS)
                    section_units = cfg_data[pidx_pkg::UNITS_W-1:0];
                else if (cfg_index == pidx_pkg::REG_MIN_SAMPLES)
                    min_samples = cfg_data[pidx_pkg::MINS_W-1:0];
            end

            // A result leaving at this edge always belongs to an older word.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("word with nothing expected, pos %0d",
                                              calibrated_pos));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (calibrated_pos !== want.pos)
                        report_mismatch($sformatf("calibrated_pos %0d, expected %0d",
                                                  calibrated_pos, want.pos));
                    if (is_locked !== want.locked)
                        report_mismatch($sformatf("is_locked %b, expected %b",
                                                  is_locked, want.locked));
                    if (mismatch !== want.conflict)
                        report_mismatch($sformatf("mismatch %b, expected %b",
                                                  mismatch, want.conflict));
                end
            end

            if (in_valid && !in_stall)
                expected_results.push_back(predict_calibration(encoder_pos, pot_pos,
                                                               index_seen, restart));

            fail_count  <= errors;
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: tb/pot_encoder_index_calibration_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Pot/encoder index calibration core testbench
// Drives directed corner words and then random calibration sessions through
// the core under several register settings and handshake idling patterns;
// a checker beside the core predicts and compares every result word.
// ============================================================================
module pot_encoder_index_calibration_core_tb;

    localparam logic signed [pidx_pkg::POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pidx_pkg::POS_W-1:0] POS_MIN = 32'sh8000_0000;

    // Random words per register setting; six settings follow the directed part.
    localparam int PHASE_WORDS = 52;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;

    logic                              cfg_wr_en = 1'b0;
    logic [pidx_pkg::CFG_IDX_W-1:0]    cfg_index = pidx_pkg::REG_SECTION_UNITS;
    logic [pidx_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [pidx_pkg::POS_W-1:0] encoder_pos = '0;
    logic signed [pidx_pkg::POS_W-1:0] pot_pos = '0;
    logic                              index_seen = 1'b0;
    logic                              restart = 1'b0;

    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [pidx_pkg::POS_W-1:0] calibrated_pos;
    logic                              is_locked;
    logic                              mismatch;

    int                                fail_count;
    int                                outstanding;

    // Idling odds in percent for the word source and the result sink.
    int                                send_idle_pct = 9;
    int                                recv_idle_pct = 72;

    int                                words_sent = 0;
    longint                            cur_units = 256;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pot_encoder_index_calibration_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .encoder_pos    (encoder_pos),
        .pot_pos        (pot_pos),
        .index_seen     (index_seen),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .calibrated_pos (calibrated_pos),
        .is_locked      (is_locked),
        .mismatch       (mismatch)
    );

    index_calibration_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .encoder_pos    (encoder_pos),
        .pot_pos        (pot_pos),
        .index_seen     (index_seen),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .calibrated_pos (calibrated_pos),
        .is_locked      (is_locked),
        .mismatch       (mismatch),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // The result sink stalls at random; the odds change between the phases of
    // the run so that stalls land both in short and in long calibrations.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offers one word, possibly after a few idle cycles, and returns at the
    // edge that accepted it. The valid line is left high so that a following
    // word can go out back to back without a dip.
    task automatic send_word(input logic signed [pidx_pkg::POS_W-1:0] enc,
                             input logic signed [pidx_pkg::POS_W-1:0] pot,
                             input logic idx,
                             input logic rst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        encoder_pos <= enc;
        pot_pos     <= pot;
        index_seen  <= idx;
        restart     <= rst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Registers may only change while the core holds no word, so the source
    // is drained first. Every call writes both registers; the minimum sample
    // count goes out with random filler in the unused upper data bits.
    task automatic load_config(input logic [pidx_pkg::UNITS_W-1:0] units,
                               input logic [pidx_pkg::MINS_W-1:0] mins);
        logic [31:0] filler;
        filler   = $urandom;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= pidx_pkg::REG_SECTION_UNITS;
        cfg_data  <= units;
        @(posedge clk);
        cfg_index <= pidx_pkg::REG_MIN_SAMPLES;
        cfg_data  <= {filler[pidx_pkg::CFG_DATA_W-pidx_pkg::MINS_W-1:0], mins};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_units = (units == 0) ? 1 : longint'({40'd0, units});
    endtask

    // One well-formed calibration run: a restart, then a walk of samples whose
    // pot reading tracks the encoder plus a hidden offset with a little noise.
    // Most index pulses sit exactly on a section boundary of the absolute
    // position, which should lock and then agree; a few sit anywhere, which
    // may lock to a wrong section or raise the sticky mismatch.
    task automatic run_session();
        longint      off, pos, k, enc_l, pot_l, nmax;
        int unsigned samples, r;
        logic        pulse;
        nmax = cur_units / 8;
        if (nmax > 4096)
            nmax = 4096;
        off = longint'($urandom_range(0, 2097152)) - 1048576;
        pos = longint'($urandom_range(0, 2097152)) - 1048576;
        samples = $urandom_range(5, 30);
        send_word($urandom, $urandom, 1'($urandom_range(1)), 1'b1);
        repeat (samples)
        begin
            pos   = pos + longint'($urandom_range(0, 4000)) - 2000;
            enc_l = pos;
            pulse = 1'b0;
            r     = $urandom_range(99);
            if (r < 15)
            begin
                k     = (pos + off) / cur_units;
                enc_l = k * cur_units - off;
                pulse = 1'b1;
            end
            else if (r < 20)
            begin
                pulse = 1'b1;
            end
            pot_l = enc_l + off + longint'($urandom_range(0, 32'(2 * nmax))) - nmax;
            send_word(enc_l[pidx_pkg::POS_W-1:0], pot_l[pidx_pkg::POS_W-1:0], pulse, 1'b0);
        end
    endtask

    // Fully random words, now and then a restart among them.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_word($urandom, $urandom, 1'($urandom_range(1)), $urandom_range(19) == 0);
    endtask

    // Watchdog: far beyond the slowest legal run of every word calibrating
    // behind long gaps and long stalls.
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          phase;
        int          phase_end;
        logic [23:0] units;
        logic [15:0] mins;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values: range extremes,
        // a pulse that arrives too early to calibrate, and a restart that
        // carries every other flag set.
        send_word(POS_MIN, POS_MAX, 1'b0, 1'b0);
        send_word(POS_MAX, POS_MIN, 1'b1, 1'b0);
        send_word(POS_MAX, POS_MIN, 1'b1, 1'b1);
        send_word(0, 0, 1'b0, 1'b0);

        // One sample is enough here, so the first pulse locks at once. The
        // extreme spread drives the candidate offset past the top of the
        // range, then the output sum saturates; a later disagreeing pulse
        // sets the sticky flag, and the restart drops it again before the
        // same game is played towards the bottom of the range.
        load_config(24'd256, 16'd1);
        send_word(POS_MIN, POS_MAX, 1'b1, 1'b0);
        send_word(POS_MAX, 0, 1'b0, 1'b0);
        send_word(-1, -1, 1'b1, 1'b0);
        send_word(0, 0, 1'b0, 1'b1);
        send_word(POS_MAX, POS_MIN, 1'b1, 1'b0);
        send_word(POS_MIN, 0, 1'b0, 1'b0);

        // Zero section width behaves as one unit, zero minimum as one sample.
        load_config(24'd0, 16'd0);
        send_word(0, 0, 1'b0, 1'b1);
        send_word(1000, 1300, 1'b1, 1'b0);
        send_word(-1000, -700, 1'b1, 1'b0);
        send_word(5, 3, 1'b1, 1'b0);

        // Both registers at their all-ones extreme: pulses never calibrate.
        load_config(24'hFF_FFFF, 16'hFFFF);
        send_word(0, 0, 1'b0, 1'b1);
        send_word(100, -100, 1'b1, 1'b0);
        send_word(POS_MIN, POS_MAX, 1'b0, 1'b0);

        // Rounding of the section: an exact half lands on zero, while a negative
        // and a positive whole multiple of the section keep their own section.
        load_config(24'd256, 16'd2);
        send_word(0, 0, 1'b0, 1'b1);
        send_word(0, 128, 1'b0, 1'b0);
        send_word(0, 128, 1'b1, 1'b0);
        send_word(-384, -256, 1'b1, 1'b0);
        send_word(640, 768, 1'b1, 1'b0);

        // Random part: six register settings, two per idling pattern. The
        // source idles rarely and the sink often, then the reverse, then the
        // last two settings run with no idling on either side.
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    units = 24'd256;
                    mins  = 16'd3;
                end
                1:
                begin
                    units = 24'($urandom_range(1, 4096));
                    mins  = 16'($urandom_range(1, 20));
                end
                2:
                begin
                    units = 24'hFF_FFFF;
                    mins  = 16'd1;
                end
                3:
                begin
                    units = 24'($urandom_range(16, 65535));
                    mins  = 16'($urandom_range(1, 30));
                end
                4:
                begin
                    units = 24'd1;
                    mins  = 16'd2;
                end
                default:
                begin
                    units = 24'($urandom_range(1, 24'hFF_FFFF));
                    mins  = 16'($urandom_range(1, 10));
                end
            endcase
            if (phase == 2)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 9;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_config(units, mins);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(9) < 8)
                    run_session();
                else
                    send_noise();
            end
        end

        // Drain: wait for the last result word, then give the core the length
        // of one full calibration to show any stray word.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/pidx_pkg.sv
hdl/pidx_div.sv
hdl/pot_encoder_index_calibration_core.sv
tb/index_calibration_checker.sv
tb/pot_encoder_index_calibration_core_tb.sv
